// ===== hdl/message_ring_queue_with_waiters_top_assert.svh =====
// Assertion macros for the ring mailbox; clocked on clk, off while rst_n is low.
`ifndef MESSAGE_RING_QUEUE_WITH_WAITERS_TOP_ASSERT_SVH
`define MESSAGE_RING_QUEUE_WITH_WAITERS_TOP_ASSERT_SVH

// Same-cycle implication
`define MRQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ring mailbox assertion failed");

// Next-cycle implication
`define MRQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ring mailbox assertion failed");

`endif

// ===== hdl/mrq_pkg.sv =====
package mrq_pkg;

  // Fixed limits of the mailbox
  localparam int MAX_TASKS     = 16;
  localparam int MAX_MSG_BYTES = 8;

  // Request codes
  localparam logic [1:0] REQ_ENQ = 2'd0;
  localparam logic [1:0] REQ_DEQ = 2'd1;
  localparam logic [1:0] REQ_CLR = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_SUSP  = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  task_id;
    logic        blocking;
    logic [3:0]  msg_len;
    logic [63:0] msg_data;
  } mrq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_data;
    logic [15:0] wake_mask;
    logic [8:0]  free_bytes;
  } mrq_out_t;

endpackage

// ===== hdl/mrq_ram.sv =====
module mrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/message_ring_queue_with_waiters_top.sv =====
// Byte ring mailbox with task waiter masks. One request is worked on at a time; the byte
// store is a single RAM with one write and one registered read port, so it moves one byte a
// cycle. A clear, and reset, is followed by a zeroing pass over all QUEUE_DEPTH RAM entries
// during which no request is taken. After each write of the size register the pointers are
// reduced modulo the new size by a bit-serial remainder unit, which holds off requests while
// it runs. A request is taken in idle and evaluated, then its bytes are moved and its result
// is presented. A result waits in an output register, and the next request is taken while
// it waits.
module message_ring_queue_with_waiters_top #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mrq_pkg::mrq_in_t   in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output mrq_pkg::mrq_out_t  out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [8:0]         cfg_data
);

  localparam int CAP = (QUEUE_DEPTH > 511) ? 511 : QUEUE_DEPTH;
  localparam logic [8:0] CAP_SIZE = 9'(CAP);
  localparam logic [8:0] RST_SIZE = (CAP < 256) ? CAP_SIZE : 9'd256;
  localparam int PW = $clog2(CAP);
  localparam int BW = (PW > 1) ? $clog2(PW) : 1;
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam logic [AW-1:0] ZERO_LAST = AW'(QUEUE_DEPTH - 1);
  localparam logic [BW-1:0] BIT_TOP = BW'(PW - 1);

  typedef enum logic [2:0] {
    S_ZERO, S_IDLE, S_REDUCE, S_EVAL, S_ENQ, S_DEQ, S_FINISH
  } state_t;

  state_t               state_r, state_nxt;
  logic [8:0]           cfg_size_r, cfg_size_nxt;
  logic                 pend_r, pend_nxt;
  logic [PW-1:0]        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW-1:0]        wpm_r, wpm_nxt, rpm_r, rpm_nxt;
  logic [8:0]           free_r, free_nxt;
  logic [15:0]          send_r, send_nxt, recv_r, recv_nxt;
  logic [AW-1:0]        zcnt_r, zcnt_nxt;
  logic [8:0]           wrem_r, wrem_nxt, rrem_r, rrem_nxt;
  logic [BW-1:0]        bidx_r, bidx_nxt;
  mrq_pkg::mrq_in_t     item_r, item_nxt;
  logic [3:0]           cnt_r, cnt_nxt;
  logic                 rvalid_r, rvalid_nxt;
  logic [2:0]           rslot_r, rslot_nxt;
  logic [1:0]           status_r, status_nxt;
  logic [15:0]          wake_r, wake_nxt;
  logic [63:0]          rdata_r, rdata_nxt;
  logic                 ov_r, ov_nxt;
  mrq_pkg::mrq_out_t    out_r, out_nxt;

  logic [8:0]           size_w;
  logic [8:0]           stored_w;
  logic [3:0]           n_w;
  logic [15:0]          tbit_w;
  logic [PW:0]          wsum_w, rsum_w;
  logic [PW-1:0]        wpm_inc, rpm_inc;
  logic [9:0]           wt_w, rt_w, wstep_w, rstep_w;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [7:0]           ram_wdata;
  logic [7:0]           ram_rdata;

  mrq_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (AW'(rpm_r)),
    .rdata (ram_rdata)
  );

  // Clamp the size register and the message length, and derive the stored byte count and the task bit
  always_comb begin
    if (cfg_size_r == 9'd0) begin
      size_w = 9'd1;
    end else if (cfg_size_r > CAP_SIZE) begin
      size_w = CAP_SIZE;
    end else begin
      size_w = cfg_size_r;
    end
    stored_w = (free_r >= size_w) ? 9'd0 : size_w - free_r;
    n_w = (item_r.msg_len > 4'(mrq_pkg::MAX_MSG_BYTES)) ?
          4'(mrq_pkg::MAX_MSG_BYTES) : item_r.msg_len;
    tbit_w = (32'(item_r.task_id) < mrq_pkg::MAX_TASKS) ?
             (16'd1 << item_r.task_id) : 16'd0;
  end

  // Advance pointers with wrap at the size in use
  always_comb begin
    wsum_w = {1'b0, wpm_r} + (PW+1)'(1);
    rsum_w = {1'b0, rpm_r} + (PW+1)'(1);
    wpm_inc = (10'(wsum_w) == 10'(size_w)) ? '0 : wsum_w[PW-1:0];
    rpm_inc = (10'(rsum_w) == 10'(size_w)) ? '0 : rsum_w[PW-1:0];
  end

  // One restoring remainder step for each pointer
  always_comb begin
    wt_w = {wrem_r, wp_r[bidx_r]};
    rt_w = {rrem_r, rp_r[bidx_r]};
    wstep_w = (wt_w >= {1'b0, size_w}) ? wt_w - {1'b0, size_w} : wt_w;
    rstep_w = (rt_w >= {1'b0, size_w}) ? rt_w - {1'b0, size_w} : rt_w;
  end

  // Sequence one request through the ring store, with the zeroing pass and the pointer reduction
  always_comb begin
    state_nxt    = state_r;
    cfg_size_nxt = cfg_size_r;
    pend_nxt     = pend_r;
    wp_nxt       = wp_r;
    rp_nxt       = rp_r;
    wpm_nxt      = wpm_r;
    rpm_nxt      = rpm_r;
    free_nxt     = free_r;
    send_nxt     = send_r;
    recv_nxt     = recv_r;
    zcnt_nxt     = zcnt_r;
    wrem_nxt     = wrem_r;
    rrem_nxt     = rrem_r;
    bidx_nxt     = bidx_r;
    item_nxt     = item_r;
    cnt_nxt      = cnt_r;
    rvalid_nxt   = 1'b0;
    rslot_nxt    = cnt_r[2:0];
    status_nxt   = status_r;
    wake_nxt     = wake_r;
    rdata_nxt    = rdata_r;
    ov_nxt       = ov_r;
    out_nxt      = out_r;
    ram_we       = 1'b0;
    ram_waddr    = AW'(wpm_r);
    ram_wdata    = item_r.msg_data[{cnt_r[2:0], 3'b000} +: 8];

    // Drop the result once taken
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_ZERO: begin
        ram_we    = 1'b1;
        ram_waddr = zcnt_r;
        ram_wdata = 8'd0;
        zcnt_nxt  = zcnt_r + AW'(1);
        if (zcnt_r == ZERO_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pend_r) begin
          pend_nxt  = 1'b0;
          wrem_nxt  = 9'd0;
          rrem_nxt  = 9'd0;
          bidx_nxt  = BIT_TOP;
          state_nxt = S_REDUCE;
        end else if (in_valid) begin
          item_nxt  = in_item;
          state_nxt = S_EVAL;
        end
      end
      S_REDUCE: begin
        wrem_nxt = wstep_w[8:0];
        rrem_nxt = rstep_w[8:0];
        if (bidx_r == '0) begin
          wpm_nxt   = wstep_w[PW-1:0];
          rpm_nxt   = rstep_w[PW-1:0];
          state_nxt = S_IDLE;
        end else begin
          bidx_nxt = bidx_r - BW'(1);
        end
      end
      S_EVAL: begin
        status_nxt = mrq_pkg::STAT_OK;
        wake_nxt   = 16'd0;
        rdata_nxt  = 64'd0;
        cnt_nxt    = 4'd0;
        state_nxt  = S_FINISH;
        case (item_r.req_type)
          mrq_pkg::REQ_ENQ: begin
            if (9'(n_w) > free_r) begin
              if (item_r.blocking) begin
                send_nxt   = send_r | tbit_w;
                status_nxt = mrq_pkg::STAT_SUSP;
              end else begin
                status_nxt = mrq_pkg::STAT_FULL;
              end
            end else begin
              // Settle the raw pointer on the reduced one, even for an empty message
              wp_nxt   = wpm_r;
              free_nxt = free_r - 9'(n_w);
              wake_nxt = recv_r;
              recv_nxt = 16'd0;
              if (n_w != 4'd0) begin
                state_nxt = S_ENQ;
              end
            end
          end
          mrq_pkg::REQ_DEQ: begin
            if (9'(n_w) > stored_w) begin
              if (item_r.blocking) begin
                recv_nxt   = recv_r | tbit_w;
                status_nxt = mrq_pkg::STAT_SUSP;
              end else begin
                status_nxt = mrq_pkg::STAT_EMPTY;
              end
            end else begin
              // Settle the raw pointer on the reduced one, even for an empty message
              rp_nxt   = rpm_r;
              free_nxt = free_r + 9'(n_w);
              wake_nxt = send_r;
              send_nxt = 16'd0;
              if (n_w != 4'd0) begin
                state_nxt = S_DEQ;
              end
            end
          end
          mrq_pkg::REQ_CLR: begin
            wp_nxt   = '0;
            rp_nxt   = '0;
            wpm_nxt  = '0;
            rpm_nxt  = '0;
            free_nxt = size_w;
            send_nxt = 16'd0;
            recv_nxt = 16'd0;
          end
          default: begin
          end
        endcase
      end
      S_ENQ: begin
        ram_we  = 1'b1;
        wpm_nxt = wpm_inc;
        wp_nxt  = wpm_inc;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r + 4'd1 == n_w) begin
          state_nxt = S_FINISH;
        end
      end
      S_DEQ: begin
        // Issue one read a cycle, collect its registered data in the next cycle
        if (cnt_r != n_w) begin
          rvalid_nxt = 1'b1;
          rpm_nxt    = rpm_inc;
          rp_nxt     = rpm_inc;
          cnt_nxt    = cnt_r + 4'd1;
        end
        if (rvalid_r) begin
          rdata_nxt[{rslot_r, 3'b000} +: 8] = ram_rdata;
          if (cnt_r == n_w) begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (!ov_r || !out_stall) begin
          ov_nxt             = 1'b1;
          out_nxt.status     = status_r;
          out_nxt.read_data  = rdata_r;
          out_nxt.wake_mask  = wake_r;
          out_nxt.free_bytes = free_r;
          zcnt_nxt           = '0;
          state_nxt = (item_r.req_type == mrq_pkg::REQ_CLR) ? S_ZERO : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Take a size write and schedule the pointer reduction
    if (cfg_valid) begin
      cfg_size_nxt = cfg_data;
      pend_nxt     = 1'b1;
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_ZERO;
      cfg_size_r <= 9'd256;
      pend_r     <= 1'b0;
      wp_r       <= '0;
      rp_r       <= '0;
      wpm_r      <= '0;
      rpm_r      <= '0;
      free_r     <= RST_SIZE;
      send_r     <= 16'd0;
      recv_r     <= 16'd0;
      zcnt_r     <= '0;
      rvalid_r   <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cfg_size_r <= cfg_size_nxt;
      pend_r     <= pend_nxt;
      wp_r       <= wp_nxt;
      rp_r       <= rp_nxt;
      wpm_r      <= wpm_nxt;
      rpm_r      <= rpm_nxt;
      free_r     <= free_nxt;
      send_r     <= send_nxt;
      recv_r     <= recv_nxt;
      zcnt_r     <= zcnt_nxt;
      rvalid_r   <= rvalid_nxt;
      ov_r       <= ov_nxt;
    end
    wrem_r   <= wrem_nxt;
    rrem_r   <= rrem_nxt;
    bidx_r   <= bidx_nxt;
    item_r   <= item_nxt;
    cnt_r    <= cnt_nxt;
    rslot_r  <= rslot_nxt;
    status_r <= status_nxt;
    wake_r   <= wake_nxt;
    rdata_r  <= rdata_nxt;
    out_r    <= out_nxt;
  end

  assign in_stall  = !((state_r == S_IDLE) && !pend_r);
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_item  = out_r;

`include "message_ring_queue_with_waiters_top_assert.svh"

  `MRQ_ASSERT_IMP(a_ptr_in_ring, (state_r == S_IDLE) && !pend_r,
                  (9'(wpm_r) < size_w) && (9'(rpm_r) < size_w))
  `MRQ_ASSERT_IMP(a_wake_on_success, out_valid && (out_item.status != mrq_pkg::STAT_OK),
                  out_item.wake_mask == 16'd0)
  `MRQ_ASSERT_IMP(a_rdata_on_success, out_valid && (out_item.status != mrq_pkg::STAT_OK),
                  out_item.read_data == 64'd0)
  `MRQ_ASSERT_NEXT(a_accept_to_eval, in_valid && !in_stall, state_r == S_EVAL)

endmodule
